// ===== rtl/bvm_pkg.sv =====
// bvm_pkg: shared constants, codes and types of the bytecode machine core
// used by every module of the core and by the port checker; no dependencies
`default_nettype none

package bvm_pkg;

    localparam int CODE_DEPTH = 1024;
    localparam int CODE_AW    = $clog2(CODE_DEPTH);
    localparam int REG_COUNT  = 16;
    localparam int REG_AW     = $clog2(REG_COUNT);
    localparam int WORD_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int ITEM_AW    = 10;
    localparam int NEXT_AW    = 10;

    // request kinds on the input stream
    localparam logic [1:0] ITEM_WRITE = 2'd0;
    localparam logic [1:0] ITEM_STEP  = 2'd1;
    localparam logic [1:0] ITEM_START = 2'd2;

    // instruction opcodes
    localparam logic [BYTE_W-1:0] OP_HALT = 8'd0;
    localparam logic [BYTE_W-1:0] OP_NOP  = 8'd1;
    localparam logic [BYTE_W-1:0] OP_TRAP = 8'd2;
    localparam logic [BYTE_W-1:0] OP_ADD  = 8'd3;
    localparam logic [BYTE_W-1:0] OP_SUB  = 8'd4;
    localparam logic [BYTE_W-1:0] OP_LDA  = 8'd9;
    localparam logic [BYTE_W-1:0] OP_BNZ  = 8'd12;

    localparam logic [REG_AW-1:0] TRAP_REG = REG_AW'(15);

    typedef logic [CODE_AW-1:0] code_addr_t;
    typedef logic [REG_AW-1:0]  reg_addr_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [NEXT_AW-1:0] next_addr_t;

    typedef struct packed {
        logic              en;
        logic              we;
        code_addr_t        addr;
        logic [BYTE_W-1:0] wdata;
    } code_req_t;

    typedef struct packed {
        logic      clear;
        logic      rd_en;
        reg_addr_t rd_addr;
        logic      wr_en;
        reg_addr_t wr_addr;
        word_t     wr_data;
    } reg_req_t;

    typedef struct packed {
        logic              trap_valid;
        logic [BYTE_W-1:0] trap_char;
        logic              halted;
        logic              bad_opcode;
        logic              zero_flag;
        next_addr_t        next_addr;
    } vm_result_t;

endpackage

`default_nettype wire

// ===== rtl/bvm_code_mem.sv =====
// bvm_code_mem: single-port code byte store, registered read
// depends on bvm_pkg for the request type and store depth
`default_nettype none

module bvm_code_mem (
    input  wire logic                      clk,
    input  wire bvm_pkg::code_req_t        req,
    output logic [bvm_pkg::BYTE_W-1:0]     rdata
);

    logic [bvm_pkg::BYTE_W-1:0] mem [bvm_pkg::CODE_DEPTH];
    logic [bvm_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/bvm_reg_file.sv =====
// bvm_reg_file: sixteen 32-bit registers in a synchronous memory, one read
// and one write port, valid bits make cleared entries read as zero; uses bvm_pkg
`default_nettype none

module bvm_reg_file (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bvm_pkg::reg_req_t  req,
    output bvm_pkg::word_t          rdata
);

    bvm_pkg::word_t mem [bvm_pkg::REG_COUNT];
    logic [bvm_pkg::REG_COUNT-1:0] valid_reg;
    bvm_pkg::word_t rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clear)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/bvm_seq.sv =====
// bvm_seq: instruction sequencer, fetches code bytes, drives the register
// file, holds pointer, flags and the result register; uses bvm_pkg
`default_nettype none

module bvm_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    in_opcode,
    input  wire logic [bvm_pkg::ITEM_AW-1:0]   in_code_addr,
    input  wire logic [bvm_pkg::BYTE_W-1:0]    in_code_byte,
    output bvm_pkg::code_req_t                 code_req,
    input  wire logic [bvm_pkg::BYTE_W-1:0]    code_rdata,
    output bvm_pkg::reg_req_t                  reg_req,
    input  wire bvm_pkg::word_t                reg_rdata,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output bvm_pkg::vm_result_t                out_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_IMM,
        S_RX,
        S_RY,
        S_EXEC,
        S_TRAP,
        S_DONE
    } state_t;

    state_t                      state_reg, state_next;
    bvm_pkg::code_addr_t         ip_reg, ip_next;
    logic                        zero_reg, zero_next;
    logic                        halt_reg, halt_next;
    logic                        trap_reg, trap_next;
    logic [bvm_pkg::BYTE_W-1:0]  tchar_reg, tchar_next;
    logic                        bad_reg, bad_next;
    logic [bvm_pkg::BYTE_W-1:0]  opc_reg, opc_next;
    bvm_pkg::word_t              imm_reg, imm_next;
    bvm_pkg::word_t              a_reg, a_next;
    bvm_pkg::reg_addr_t          y_reg, y_next;
    logic [1:0]                  cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    bvm_pkg::vm_result_t         out_res_reg, out_res_next;

    bvm_pkg::word_t              imm_word;
    bvm_pkg::word_t              alu_b;
    bvm_pkg::word_t              alu_res;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_result = out_res_reg;

    assign imm_word = {code_rdata, imm_reg[bvm_pkg::WORD_W-1:bvm_pkg::BYTE_W]};
    assign alu_b    = (opc_reg == bvm_pkg::OP_LDA) ? imm_reg : reg_rdata;
    assign alu_res  = (opc_reg == bvm_pkg::OP_SUB) ? a_reg - alu_b : a_reg + alu_b;

    always_comb
    begin
        state_next     = state_reg;
        ip_next        = ip_reg;
        zero_next      = zero_reg;
        halt_next      = halt_reg;
        trap_next      = trap_reg;
        tchar_next     = tchar_reg;
        bad_next       = bad_reg;
        opc_next       = opc_reg;
        imm_next       = imm_reg;
        a_next         = a_reg;
        y_next         = y_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_res_next   = out_res_reg;
        code_req       = '0;
        reg_req        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    trap_next  = 1'b0;
                    tchar_next = '0;
                    bad_next   = 1'b0;
                    state_next = S_DONE;
                    case (in_opcode)
                        bvm_pkg::ITEM_WRITE:
                        begin
                            code_req.en    = 1'b1;
                            code_req.we    = 1'b1;
                            code_req.addr  = bvm_pkg::code_addr_t'(in_code_addr);
                            code_req.wdata = in_code_byte;
                        end
                        bvm_pkg::ITEM_START:
                        begin
                            reg_req.clear = 1'b1;
                            ip_next       = '0;
                            zero_next     = 1'b0;
                            halt_next     = 1'b0;
                        end
                        bvm_pkg::ITEM_STEP:
                        begin
                            if (!halt_reg)
                            begin
                                code_req.en   = 1'b1;
                                code_req.addr = ip_reg;
                                ip_next       = ip_reg + bvm_pkg::code_addr_t'(1);
                                state_next    = S_OP;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_OP:
            begin
                opc_next   = code_rdata;
                cnt_next   = '0;
                state_next = S_DONE;
                case (code_rdata)
                    bvm_pkg::OP_HALT:
                    begin
                        halt_next = 1'b1;
                    end
                    bvm_pkg::OP_NOP:
                    begin
                        state_next = S_DONE;
                    end
                    bvm_pkg::OP_TRAP:
                    begin
                        reg_req.rd_en   = 1'b1;
                        reg_req.rd_addr = bvm_pkg::TRAP_REG;
                        state_next      = S_TRAP;
                    end
                    bvm_pkg::OP_ADD, bvm_pkg::OP_SUB:
                    begin
                        code_req.en   = 1'b1;
                        code_req.addr = ip_reg;
                        ip_next       = ip_reg + bvm_pkg::code_addr_t'(1);
                        state_next    = S_RX;
                    end
                    bvm_pkg::OP_LDA, bvm_pkg::OP_BNZ:
                    begin
                        code_req.en   = 1'b1;
                        code_req.addr = ip_reg;
                        ip_next       = ip_reg + bvm_pkg::code_addr_t'(1);
                        state_next    = S_IMM;
                    end
                    default:
                    begin
                        bad_next = 1'b1;
                    end
                endcase
            end

            S_IMM:
            begin
                imm_next = imm_word;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg != 2'd3)
                begin
                    code_req.en   = 1'b1;
                    code_req.addr = ip_reg;
                    ip_next       = ip_reg + bvm_pkg::code_addr_t'(1);
                end
                else if (opc_reg == bvm_pkg::OP_BNZ)
                begin
                    if (!zero_reg)
                    begin
                        ip_next = bvm_pkg::code_addr_t'(imm_word);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    code_req.en   = 1'b1;
                    code_req.addr = ip_reg;
                    ip_next       = ip_reg + bvm_pkg::code_addr_t'(1);
                    state_next    = S_RX;
                end
            end

            S_RX:
            begin
                reg_req.rd_en   = 1'b1;
                reg_req.rd_addr = code_rdata[bvm_pkg::REG_AW-1:0];
                code_req.en     = 1'b1;
                code_req.addr   = ip_reg;
                ip_next         = ip_reg + bvm_pkg::code_addr_t'(1);
                state_next      = S_RY;
            end

            S_RY:
            begin
                a_next          = reg_rdata;
                y_next          = code_rdata[bvm_pkg::REG_AW-1:0];
                reg_req.rd_en   = 1'b1;
                reg_req.rd_addr = code_rdata[bvm_pkg::REG_AW-1:0];
                state_next      = S_EXEC;
            end

            S_EXEC:
            begin
                reg_req.wr_en   = 1'b1;
                reg_req.wr_addr = y_reg;
                reg_req.wr_data = alu_res;
                zero_next       = (alu_res == '0);
                state_next      = S_DONE;
            end

            S_TRAP:
            begin
                trap_next  = 1'b1;
                tchar_next = reg_rdata[bvm_pkg::BYTE_W-1:0];
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next          = 1'b1;
                    out_res_next.trap_valid = trap_reg;
                    out_res_next.trap_char  = tchar_reg;
                    out_res_next.halted     = halt_reg;
                    out_res_next.bad_opcode = bad_reg;
                    out_res_next.zero_flag  = zero_reg;
                    out_res_next.next_addr  = bvm_pkg::next_addr_t'(ip_reg);
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ip_reg        <= '0;
            zero_reg      <= 1'b0;
            halt_reg      <= 1'b0;
            trap_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ip_reg        <= ip_next;
            zero_reg      <= zero_next;
            halt_reg      <= halt_next;
            trap_reg      <= trap_next;
            bad_reg       <= bad_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tchar_reg   <= tchar_next;
        opc_reg     <= opc_next;
        imm_reg     <= imm_next;
        a_reg       <= a_next;
        y_reg       <= y_next;
        out_res_reg <= out_res_next;
    end

endmodule

`default_nettype wire

// ===== rtl/bytecode_vm_core.sv =====
// bytecode_vm_core: top level of the byte-coded machine, stream ports and packing
// depends on bvm_pkg, bvm_code_mem, bvm_reg_file and bvm_seq
//
//   port group   dir   tdata                                tuser
//   s_axis       in    code_addr, code_byte                 opcode
//   m_axis       out   trap_char, halted, bad_opcode,       trap_valid
//                      zero_flag, next_addr
//
// every request ends in S_DONE, which loads the result register; an unhalted step fetches its
// opcode in S_OP, then goes through S_IMM (lda, bnz), S_RX, S_RY and S_EXEC (add, sub, lda)
// or S_TRAP (trap); the single-port code store gives one code byte per cycle
// one request at a time; the result register lets the next request enter
// while the previous result waits on m_axis_tready
// rst_n clears pointer, flags and register valid bits; the code store is not cleared
`default_nettype none

module bytecode_vm_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,   // code_addr[9:0], code_byte[17:10], zero pad
    input  wire logic [1:0]   s_axis_tuser,   // opcode[1:0]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // trap_char[7:0], halted[8], bad_opcode[9],
                                              // zero_flag[10], next_addr[20:11], zero pad
    output logic              m_axis_tuser    // trap_valid
);

    bvm_pkg::code_req_t          code_req;
    logic [bvm_pkg::BYTE_W-1:0]  code_rdata;
    bvm_pkg::reg_req_t           reg_req;
    bvm_pkg::word_t              reg_rdata;
    bvm_pkg::vm_result_t         result;

    bvm_code_mem u_code_mem (
        .clk   (clk),
        .req   (code_req),
        .rdata (code_rdata)
    );

    bvm_reg_file u_reg_file (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (reg_req),
        .rdata (reg_rdata)
    );

    bvm_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_opcode    (s_axis_tuser),
        .in_code_addr (s_axis_tdata[9:0]),
        .in_code_byte (s_axis_tdata[17:10]),
        .code_req     (code_req),
        .code_rdata   (code_rdata),
        .reg_req      (reg_req),
        .reg_rdata    (reg_rdata),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_result   (result)
    );

    assign m_axis_tdata = {3'b000, result.next_addr, result.zero_flag,
                           result.bad_opcode, result.halted, result.trap_char};
    assign m_axis_tuser = result.trap_valid;

endmodule

`default_nettype wire

// ===== rtl/bvm_checker.sv =====
// bvm_props: port-level assertions for bytecode_vm_core, bound to the top level
// depends on bytecode_vm_core port names only
`default_nettype none

module bvm_props (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [23:0]  m_axis_tdata,
    input  wire logic         m_axis_tuser
);

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // a trap never comes with a skipped opcode
    a_trap_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[9])
        else $error("trap and bad opcode in one result");

    // a step that traps or skips a byte was not halted
    a_event_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser || m_axis_tdata[9]) |-> !m_axis_tdata[8])
        else $error("trap or bad opcode reported while halted");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind bytecode_vm_core bvm_props u_bvm_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/bvm_checker.sv =====
`timescale 1ns / 100ps
// bvm_checker: watches both stream ports of bytecode_vm_core, predicts the status
// result of every accepted request and compares it field by field; depends on bvm_pkg

module bvm_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // code_addr[9:0], code_byte[17:10], zero pad
    input  wire logic [1:0]  s_axis_tuser,   // opcode[1:0]
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata,   // trap_char[7:0], halted[8], bad_opcode[9],
                                             // zero_flag[10], next_addr[20:11], zero pad
    input  wire logic        m_axis_tuser,   // trap_valid
    output int               errors,
    output int               outstanding
);
    import bvm_pkg::*;

    localparam int PRINT_LIMIT = 40;

    logic [BYTE_W-1:0] code_mem [CODE_DEPTH];
    word_t             regs [REG_COUNT];
    code_addr_t        ip;
    logic              zf;
    logic              hm;

    vm_result_t pending_status [$];
    vm_result_t want;
    vm_result_t got;
    int         mismatches = 0;
    int         waiting = 0;
    int         result_no = 0;

    assign errors      = mismatches;
    assign outstanding = waiting;

    task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                   input logic [31:0] got_val);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("tb: result %0d, %s: expected %0h, got %0h",
                     result_no, what, exp_val, got_val);
    endtask

    function automatic logic [BYTE_W-1:0] fetch_code();
        logic [BYTE_W-1:0] b;
        b  = code_mem[ip];
        ip = ip + code_addr_t'(1);
        return b;
    endfunction

    function automatic word_t fetch_code_word();
        word_t w;
        w = '0;
        for (int k = 0; k < 4; k++)
            w[8*k +: 8] = fetch_code();
        return w;
    endfunction

    task automatic execute_request(input logic [1:0] kind, input code_addr_t addr,
                                   input logic [BYTE_W-1:0] data);
        vm_result_t        r;
        logic [BYTE_W-1:0] op;
        logic [BYTE_W-1:0] xb;
        logic [BYTE_W-1:0] yb;
        word_t             a;
        word_t             v;
        r = '0;
        case (kind)
            ITEM_WRITE:
                code_mem[addr] = data;
            ITEM_START:
            begin
                for (int i = 0; i < REG_COUNT; i++)
                    regs[i] = '0;
                ip = '0;
                zf = 1'b0;
                hm = 1'b0;
            end
            ITEM_STEP:
            begin
                if (!hm)
                begin
                    op = fetch_code();
                    case (op)
                        OP_HALT:
                            hm = 1'b1;
                        OP_NOP:
                        begin
                        end
                        OP_TRAP:
                        begin
                            r.trap_valid = 1'b1;
                            r.trap_char  = regs[TRAP_REG][BYTE_W-1:0];
                        end
                        OP_ADD, OP_SUB:
                        begin
                            xb = fetch_code();
                            yb = fetch_code();
                            a  = regs[xb[REG_AW-1:0]];
                            v  = (op == OP_ADD) ? a + regs[yb[REG_AW-1:0]]
                                                : a - regs[yb[REG_AW-1:0]];
                            regs[yb[REG_AW-1:0]] = v;
                            zf = (v == '0);
                        end
                        OP_LDA:
                        begin
                            v  = fetch_code_word();
                            xb = fetch_code();
                            yb = fetch_code();
                            a  = regs[xb[REG_AW-1:0]] + v;
                            regs[yb[REG_AW-1:0]] = a;
                            zf = (a == '0);
                        end
                        OP_BNZ:
                        begin
                            v = fetch_code_word();
                            if (!zf)
                                ip = v[CODE_AW-1:0];
                        end
                        default:
                            r.bad_opcode = 1'b1;
                    endcase
                end
            end
            default:
            begin
            end
        endcase
        r.halted    = hm;
        r.zero_flag = zf;
        r.next_addr = next_addr_t'(ip);
        pending_status = {pending_status, r};
        waiting++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                regs[i] = '0;
            ip = '0;
            zf = 1'b0;
            hm = 1'b0;
            pending_status.delete();
            waiting = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_no++;
                got.trap_valid = m_axis_tuser;
                got.trap_char  = m_axis_tdata[7:0];
                got.halted     = m_axis_tdata[8];
                got.bad_opcode = m_axis_tdata[9];
                got.zero_flag  = m_axis_tdata[10];
                got.next_addr  = m_axis_tdata[20:11];
                if (pending_status.size() == 0)
                    report_mismatch("result with nothing expected", '0, {8'd0, m_axis_tdata});
                else
                begin
                    want = pending_status.pop_front();
                    waiting--;
                    if (got.trap_valid !== want.trap_valid)
                        report_mismatch("trap_valid", 32'(want.trap_valid),
                                        32'(got.trap_valid));
                    if (got.trap_char !== want.trap_char)
                        report_mismatch("trap_char", 32'(want.trap_char),
                                        32'(got.trap_char));
                    if (got.halted !== want.halted)
                        report_mismatch("halted", 32'(want.halted), 32'(got.halted));
                    if (got.bad_opcode !== want.bad_opcode)
                        report_mismatch("bad_opcode", 32'(want.bad_opcode),
                                        32'(got.bad_opcode));
                    if (got.zero_flag !== want.zero_flag)
                        report_mismatch("zero_flag", 32'(want.zero_flag),
                                        32'(got.zero_flag));
                    if (got.next_addr !== want.next_addr)
                        report_mismatch("next_addr", 32'(want.next_addr),
                                        32'(got.next_addr));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                execute_request(s_axis_tuser, s_axis_tdata[CODE_AW-1:0],
                                s_axis_tdata[ITEM_AW +: BYTE_W]);
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// tb: loads the code store, then starts and steps random programs on bytecode_vm_core
// through its stream ports and gives the verdict; depends on bvm_pkg, the core, bvm_checker

module tb;
    import bvm_pkg::*;

    localparam logic [1:0] ITEM_IDLE = 2'd3;
    localparam int TOTAL_ITEMS  = 1200;
    localparam int QUIET_LIMIT  = 3000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    int errors;
    int outstanding;
    int idle_phase = 0;
    int snd_idle = 21;
    int rcv_idle = 79;
    int real_items = 0;
    int step_items = 0;
    int results_seen = 0;
    int traps_seen = 0;
    int phase2_results = 0;
    int quiet = 0;
    int programs = 0;
    int wrapped = 0;
    int prog_base = 0;

    logic [BYTE_W-1:0] code_image [CODE_DEPTH];
    logic [BYTE_W-1:0] prog_q [$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    bytecode_vm_core i_dut (
        .clk,
        .rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .s_axis_tuser,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .m_axis_tuser
    );

    bvm_checker i_checker (
        .clk,
        .rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .s_axis_tuser,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .m_axis_tuser,
        .errors,
        .outstanding
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (m_axis_tuser)
                    traps_seen++;
                if (idle_phase == 2)
                    phase2_results++;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("tb: nothing moved on either port for %0d cycles", QUIET_LIMIT);
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (!held && idle_phase == 2 && phase2_results >= 40)
            begin
                held = 1'b1;
                hold_left = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    task automatic set_idle_phase(input int p);
        idle_phase <= p;
        snd_idle <= (p == 0) ? 21 : (p == 1) ? 79 : 0;
        rcv_idle <= (p == 0) ? 79 : (p == 1) ? 21 : 0;
    endtask

    task automatic send_req(input logic [1:0] kind, input code_addr_t addr,
                            input logic [BYTE_W-1:0] data);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {6'd0, data, addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        if (kind != ITEM_IDLE)
            real_items++;
        if (kind == ITEM_STEP)
            step_items++;
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    function automatic void add_instr();
        int pick;
        logic [31:0] w;
        logic [BYTE_W-1:0] xb;
        logic [BYTE_W-1:0] yb;
        pick = $urandom_range(0, 99);
        w  = $urandom;
        xb = 8'($urandom);
        yb = 8'($urandom);
        if (pick < 22)
        begin
            if ($urandom_range(0, 3) == 0)
                w = w & 32'hff;
            if ($urandom_range(0, 1) == 0)
                yb[REG_AW-1:0] = TRAP_REG;
            prog_q = {prog_q, OP_LDA};
            for (int k = 0; k < 4; k++)
                prog_q = {prog_q, w[8*k +: 8]};
            prog_q = {prog_q, xb};
            prog_q = {prog_q, yb};
        end
        else if (pick < 52)
        begin
            // equal register indices on a sub give a zero result
            if (pick >= 36 && $urandom_range(0, 2) == 0)
                yb[REG_AW-1:0] = xb[REG_AW-1:0];
            prog_q = {prog_q, (pick < 36) ? OP_ADD : OP_SUB};
            prog_q = {prog_q, xb};
            prog_q = {prog_q, yb};
        end
        else if (pick < 64)
            prog_q = {prog_q, OP_TRAP};
        else if (pick < 72)
            prog_q = {prog_q, OP_NOP};
        else if (pick < 84)
        begin
            if ($urandom_range(0, 2) != 0)
                w[CODE_AW-1:0] = code_addr_t'(prog_base + $urandom_range(0, 40));
            prog_q = {prog_q, OP_BNZ};
            for (int k = 0; k < 4; k++)
                prog_q = {prog_q, w[8*k +: 8]};
        end
        else if (pick < 90)
            prog_q = {prog_q, OP_HALT};
        else
        begin
            do
                xb = 8'($urandom);
            while (xb == OP_HALT || xb == OP_NOP || xb == OP_TRAP || xb == OP_ADD ||
                   xb == OP_SUB || xb == OP_LDA || xb == OP_BNZ);
            prog_q = {prog_q, xb};
        end
    endfunction

    task automatic run_program();
        int n;
        int steps;
        int pick;
        bit wrap;
        logic [31:0] w;
        prog_q.delete();
        wrap = ($urandom_range(0, 3) == 0);
        prog_base = wrap ? CODE_DEPTH - int'($urandom_range(1, 30)) : 0;
        n = $urandom_range(3, 12);
        for (int i = 0; i < n; i++)
            add_instr();
        if (wrap)
        begin
            // jump from address zero to a program that may run off the top of the store
            w = $urandom;
            w[CODE_AW-1:0] = code_addr_t'(prog_base);
            send_req(ITEM_WRITE, '0, OP_BNZ);
            for (int k = 0; k < 4; k++)
                send_req(ITEM_WRITE, code_addr_t'(k + 1), w[8*k +: 8]);
            wrapped++;
        end
        for (int i = 0; i < prog_q.size(); i++)
            if (!wrap || prog_base + i < CODE_DEPTH)
                send_req(ITEM_WRITE, code_addr_t'(prog_base + i), prog_q[i]);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
                send_req(ITEM_WRITE, code_addr_t'($urandom), 8'($urandom));
        if ($urandom_range(0, 9) != 0)
            send_req(ITEM_START, code_addr_t'($urandom), 8'($urandom));
        steps = n + $urandom_range(0, 4) + (wrap ? 2 : 0);
        for (int i = 0; i < steps; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_req(ITEM_IDLE, code_addr_t'($urandom), 8'($urandom));
            else if (pick < 6)
                send_req(ITEM_WRITE, code_addr_t'($urandom), 8'($urandom));
            else if (pick < 7)
                send_req(ITEM_START, code_addr_t'($urandom), 8'($urandom));
            send_req(ITEM_STEP, code_addr_t'($urandom), 8'($urandom));
        end
        programs++;
    endtask

    initial
    begin : stimulus
        for (int a = 0; a < CODE_DEPTH; a++)
            code_image[a] = 8'($urandom);
        // lda r15 = r0 + ffffffff, trap, sub r15 - r15, bnz not taken, nop, unknown
        code_image[0] = OP_LDA;
        for (int a = 1; a <= 4; a++)
            code_image[a] = 8'hff;
        code_image[5] = 8'h10;
        code_image[6] = 8'hff;
        code_image[7] = OP_TRAP;
        code_image[8] = OP_SUB;
        code_image[9] = 8'h1f;
        code_image[10] = 8'h0f;
        code_image[11] = OP_BNZ;
        for (int a = 12; a <= 15; a++)
            code_image[a] = 8'h00;
        code_image[16] = OP_NOP;
        code_image[17] = 8'hff;
        // lda r2 = 1, then a taken bnz with high target bits to 1022
        code_image[18] = OP_LDA;
        code_image[19] = 8'h01;
        for (int a = 20; a <= 23; a++)
            code_image[a] = 8'h00;
        code_image[24] = 8'h02;
        code_image[25] = OP_BNZ;
        code_image[26] = 8'hfe;
        for (int a = 27; a <= 29; a++)
            code_image[a] = 8'hff;
        // add at the top of the store, its second operand wraps to address zero
        code_image[1022] = OP_ADD;
        code_image[1023] = 8'h22;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every code byte is written before anything can fetch it
        for (int a = 0; a < CODE_DEPTH; a++)
        begin
            if (real_items >= 800 && idle_phase != 2)
                set_idle_phase(2);
            else if (real_items >= 400 && idle_phase == 0)
                set_idle_phase(1);
            send_req(ITEM_WRITE, code_addr_t'(a), code_image[a]);
        end
        send_req(ITEM_START, '0, '0);
        repeat (10) send_req(ITEM_STEP, '0, '0);
        send_req(ITEM_WRITE, '0, OP_HALT);
        send_req(ITEM_START, '1, '1);
        repeat (2) send_req(ITEM_STEP, '1, '1);
        send_req(ITEM_IDLE, '1, '1);
        send_req(ITEM_START, '0, 8'hff);

        while (real_items < TOTAL_ITEMS)
        begin
            run_program();
            if (programs % 2 == 0)
                pause_until_drained();
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("tb: %0d requests (%0d steps), %0d random programs, %0d across the store top",
                 real_items, step_items, programs, wrapped);
        $display("tb: %0d results checked, %0d traps, one long output stall, drain pauses",
                 results_seen, traps_seen);
        if (errors == 0 && outstanding == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bvm_pkg.sv
rtl/bvm_code_mem.sv
rtl/bvm_reg_file.sv
rtl/bvm_seq.sv
rtl/bytecode_vm_core.sv
rtl/bvm_checker.sv
tb/bvm_checker.sv
tb/tb.sv
